>>> design/sgtr_pkg.sv
// Shared types, constants and the 5x7 glyph table for the scaled glyph renderer.
// No dependencies; every other design file imports this package.
`default_nettype none

package sgtr_pkg;

  // Fixed glyph geometry and field widths
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int ROW_W      = $clog2(GLYPH_ROWS);
  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 4;
  localparam int BPP_W      = 3;
  localparam int OFFSET_W   = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults for top-level parameters
  localparam int SGTR_MAX_SCALE   = 8;
  localparam int SGTR_QUEUE_DEPTH = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd3;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 4'd1;
  localparam logic [COORD_W-1:0] FB_HEIGHT_RESET = 16'd480;
  localparam logic [COORD_W-1:0] PITCH_RESET     = 16'd2560;
  localparam logic [BPP_W-1:0]   BPP_RESET       = 3'd4;

  // Pixel sizes that produce output
  localparam logic [BPP_W-1:0] BPP_3 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

  // Special character codes
  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  // Glyph rows, index 0 is the top row, bit 4 the leftmost column
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  // One character to draw, handed from the front to the back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    glyph_t             rows;
    logic [SCALE_W-1:0] s;
  } job_t;

  // Scanline walker states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH
  } back_state_t;

  // Look up the glyph of a character; unknown codes get a hollow box
  function automatic glyph_t glyph_rows(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      8'h2c: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h04, 5'h08};
      8'h2e: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h4f: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h64: g = {5'h01, 5'h01, 5'h0d, 5'h13, 5'h11, 5'h13, 5'h0d};
      8'h65: g = {5'h00, 5'h00, 5'h0e, 5'h11, 5'h1f, 5'h10, 5'h0e};
      8'h66: g = {5'h06, 5'h08, 5'h08, 5'h1c, 5'h08, 5'h08, 5'h08};
      8'h69: g = {5'h04, 5'h00, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h6c: g = {5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h6f: g = {5'h00, 5'h00, 5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h72: g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      8'h74: g = {5'h08, 5'h08, 5'h1c, 5'h08, 5'h08, 5'h09, 5'h06};
      8'h77: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0a};
      default: g = {5'h1f, 5'h11, 5'h15, 5'h15, 5'h11, 5'h1f, 5'h00};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> design/scaled_glyph_text_renderer.sv
// Top level of the scaled 5x7 glyph renderer: configuration registers, front, queue, back.
// Depends on sgtr_pkg, sgtr_front, sgtr_queue and sgtr_back.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_stall    char_code, first, origin_x, origin_y
//   out       out_valid / out_stall  line_x, line_y, column_mask, line_offset, last
//   cfg       cfg_write              cfg_index, cfg_data
//
// In the scanline walker a drawn character takes a load, one cycle per scaled
// scanline while out does not hold the walker, and a final-line flush; newline, NUL
// and undrawn characters are handled in the front end and never reach the walker.
// The front end keeps taking characters while the job queue has room.
// Reset (rst, synchronous) returns the cursor to 0,0 and the registers to their defaults.
// A stall on out holds the result register and, once the held-back line waits too,
// the walker; a full queue stalls in.
`default_nettype none

module scaled_glyph_text_renderer
  import sgtr_pkg::*;
#(
  parameter int MAX_SCALE   = SGTR_MAX_SCALE,
  parameter int QUEUE_DEPTH = SGTR_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            char_code,
  input  wire logic                  first,
  input  wire logic [COORD_W-1:0]    origin_x,
  input  wire logic [COORD_W-1:0]    origin_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_W-1:0]         line_x,
  output logic [COORD_W-1:0]         line_y,
  output logic [GLYPH_COLS-1:0]      column_mask,
  output logic [OFFSET_W-1:0]        line_offset,
  output logic                       last
);

  logic [SCALE_W-1:0] scale;
  logic [COORD_W-1:0] fb_height, pitch;
  logic [BPP_W-1:0]   pixel_bytes;

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= SCALE_RESET;
      fb_height   <= FB_HEIGHT_RESET;
      pitch       <= PITCH_RESET;
      pixel_bytes <= BPP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE:     scale       <= cfg_data[SCALE_W-1:0];
        REG_FB_HEIGHT: fb_height   <= cfg_data[COORD_W-1:0];
        REG_PITCH:     pitch       <= cfg_data[COORD_W-1:0];
        REG_BPP:       pixel_bytes <= cfg_data[BPP_W-1:0];
        default:       scale       <= scale;
      endcase
    end
  end

  sgtr_front #(
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .first      (first),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .scale      (scale),
    .pixel_bytes(pixel_bytes),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  sgtr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  sgtr_back #(
    .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_job      (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .fb_height  (fb_height),
    .pitch      (pitch),
    .pixel_bytes(pixel_bytes),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_x     (line_x),
    .line_y     (line_y),
    .column_mask(column_mask),
    .line_offset(line_offset),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> design/sgtr_front.sv
// Front end: accepts characters, keeps the text cursor and queues glyphs to draw.
// Depends on sgtr_pkg.
`default_nettype none

module sgtr_front
  import sgtr_pkg::*;
#(
  parameter int MAX_SCALE = SGTR_MAX_SCALE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         char_code,
  input  wire logic               first,
  input  wire logic [COORD_W-1:0] origin_x,
  input  wire logic [COORD_W-1:0] origin_y,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic [BPP_W-1:0]   pixel_bytes,
  input  wire logic               q_full,
  output logic                    q_push,
  output job_t                    q_job
);

  logic [COORD_W-1:0] pen_x, pen_y, home_x;
  logic [COORD_W-1:0] pen_x_next, pen_y_next, home_x_next;
  logic [COORD_W-1:0] cx, cy, hx, s16, line_step, char_step;
  logic [SCALE_W-1:0] s_sat;
  logic               accept, draw_ok;

  // Saturate scale and check the pixel size
  assign s_sat   = (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;
  assign draw_ok = (s_sat != '0) && ((pixel_bytes == BPP_3) || (pixel_bytes == BPP_4));
  assign s16       = COORD_W'(s_sat);
  assign line_step = (s16 << 3) + s16;
  assign char_step = (s16 << 2) + (s16 << 1);

  // Hold input while the queue is full
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Load the origin on the first character of a string
  assign cx = first ? origin_x : pen_x;
  assign cy = first ? origin_y : pen_y;
  assign hx = first ? origin_x : home_x;

  // Classify the character and work out the cursor move
  always_comb begin
    pen_x_next  = cx;
    pen_y_next  = cy;
    home_x_next = hx;
    q_push      = 1'b0;
    if (char_code == CHAR_NEWLINE) begin
      pen_x_next = hx;
      pen_y_next = cy + line_step;
    end else if (char_code != CHAR_NUL) begin
      pen_x_next = cx + char_step;
      q_push     = accept && draw_ok;
    end
  end

  assign q_job.x    = cx;
  assign q_job.y    = cy;
  assign q_job.rows = glyph_rows(char_code);
  assign q_job.s    = s_sat;

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x  <= '0;
      pen_y  <= '0;
      home_x <= '0;
    end else if (accept) begin
      pen_x  <= pen_x_next;
      pen_y  <= pen_y_next;
      home_x <= home_x_next;
    end
  end

endmodule

`default_nettype wire

>>> design/sgtr_queue.sv
// Short queue of glyph jobs between the front end and the scanline walker.
// Depends on sgtr_pkg.
`default_nettype none

module sgtr_queue
  import sgtr_pkg::*;
#(
  parameter int DEPTH = SGTR_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sgtr_back.sv
// Back end: walks the scaled scanlines of one glyph and emits one result per lit line inside the frame height.
// Depends on sgtr_pkg.
`default_nettype none

module sgtr_back
  import sgtr_pkg::*;
#(
  parameter int MAX_SCALE = SGTR_MAX_SCALE
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire job_t                q_job,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire logic [COORD_W-1:0]  fb_height,
  input  wire logic [COORD_W-1:0]  pitch,
  input  wire logic [BPP_W-1:0]    pixel_bytes,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [COORD_W-1:0]       line_x,
  output logic [COORD_W-1:0]       line_y,
  output logic [GLYPH_COLS-1:0]    column_mask,
  output logic [OFFSET_W-1:0]      line_offset,
  output logic                     last
);

  localparam int DY_W = $clog2(MAX_SCALE + 1);

  back_state_t state, state_next;

  // Job being walked
  logic [COORD_W-1:0]    job_x;
  glyph_t                job_rows;
  logic [SCALE_W-1:0]    job_s;
  logic [ROW_W-1:0]      row;
  logic [DY_W-1:0]       dy;
  logic [COORD_W-1:0]    y;

  // Scanline held back until it is known whether it is the final one
  logic                  pend_valid;
  logic [COORD_W-1:0]    pend_x, pend_y;
  logic [GLYPH_COLS-1:0] pend_mask;
  logic [2*COORD_W-1:0]  pend_prod;

  logic [GLYPH_COLS-1:0] cand_mask;
  logic                  cand_valid, final_step, out_free, step_ok;
  logic                  load, step, push_out, push_last;
  logic [COORD_W+1:0]    x_bytes;

  // Classify the current scanline
  assign cand_mask  = job_rows[row];
  assign cand_valid = (cand_mask != '0) && (y < fb_height);
  assign final_step = (row == ROW_W'(GLYPH_ROWS - 1)) &&
                      (SCALE_W'(dy) == job_s - 1'b1);
  assign out_free   = !out_valid || !out_stall;
  assign step_ok    = !cand_valid || !pend_valid || out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!q_empty) begin
        state_next = BK_RUN;
      end
      BK_RUN:   if (step_ok && final_step) begin
        state_next = BK_FLUSH;
      end
      BK_FLUSH: if (!pend_valid || out_free) begin
        state_next = BK_IDLE;
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    push_out  = 1'b0;
    push_last = 1'b0;
    unique case (state)
      BK_IDLE: begin
        load = !q_empty;
      end
      BK_RUN: begin
        step     = step_ok;
        push_out = step_ok && cand_valid && pend_valid;
      end
      BK_FLUSH: begin
        push_out  = pend_valid && out_free;
        push_last = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a job and advance the row and line counters
  always_ff @(posedge clk) begin
    if (load) begin
      job_x    <= q_job.x;
      job_rows <= q_job.rows;
      job_s    <= q_job.s;
      row      <= '0;
      dy       <= '0;
      y        <= q_job.y;
    end else if (step) begin
      y <= y + 1'b1;
      if (SCALE_W'(dy) == job_s - 1'b1) begin
        dy  <= '0;
        row <= row + 1'b1;
      end else begin
        dy <= dy + 1'b1;
      end
    end
  end

  // Hold back a visible scanline and start its row offset product
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == BK_FLUSH && push_out) begin
      pend_valid <= 1'b0;
    end else if (step && cand_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cand_valid) begin
      pend_x    <= job_x;
      pend_y    <= y;
      pend_mask <= cand_mask;
      pend_prod <= (2*COORD_W)'(y) * (2*COORD_W)'(pitch);
    end
  end

  // Column offset: x times three or four
  assign x_bytes = (pixel_bytes == BPP_3) ?
                   ((COORD_W + 2)'({pend_x, 1'b0}) + (COORD_W + 2)'(pend_x)) :
                   {pend_x, 2'b00};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      line_x      <= pend_x;
      line_y      <= pend_y;
      column_mask <= pend_mask;
      line_offset <= OFFSET_W'(pend_prod) + OFFSET_W'(x_bytes);
      last        <= push_last;
    end
  end

endmodule

`default_nettype wire

>>> tb/sgtr_scanline_checker.sv
// Scanline checker for the scaled glyph text renderer: follows the cursor and the
// registers, works out every scanline item a character causes and compares the output.
// Depends on sgtr_pkg for widths, register indexes and character codes.
`default_nettype none

module sgtr_scanline_checker
  import sgtr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [7:0]            char_code,
  input  wire logic                  first,
  input  wire logic [COORD_W-1:0]    origin_x,
  input  wire logic [COORD_W-1:0]    origin_y,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [COORD_W-1:0]    line_x,
  input  wire logic [COORD_W-1:0]    line_y,
  input  wire logic [GLYPH_COLS-1:0] column_mask,
  input  wire logic [OFFSET_W-1:0]   line_offset,
  input  wire logic                  last,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [GLYPH_COLS-1:0] mask;
    logic [OFFSET_W-1:0]   offset;
    logic                  last;
  } scanline_t;

  scanline_t scanline_q[$];

  // Register copies and cursor
  logic [SCALE_W-1:0] scale_r;
  logic [COORD_W-1:0] fb_height_r;
  logic [COORD_W-1:0] pitch_r;
  logic [BPP_W-1:0]   bpp_r;
  logic [COORD_W-1:0] pen_x;
  logic [COORD_W-1:0] pen_y;
  logic [COORD_W-1:0] home_x;

  int errors      = 0;
  int pending_cnt = 0;

  assign fail_count  = errors;
  assign outstanding = pending_cnt;

  // Font: top row in the upper five bits, bit 4 of each row is the leftmost column
  function automatic logic [GLYPH_ROWS*GLYPH_COLS-1:0] font_rows(input logic [7:0] code);
    case (code)
      " ":     return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      ",":     return {5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h04, 5'h08};
      ".":     return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
      "H":     return {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      "O":     return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      "R":     return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      "S":     return {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      "d":     return {5'h01, 5'h01, 5'h0d, 5'h13, 5'h11, 5'h13, 5'h0d};
      "e":     return {5'h00, 5'h00, 5'h0e, 5'h11, 5'h1f, 5'h10, 5'h0e};
      "f":     return {5'h06, 5'h08, 5'h08, 5'h1c, 5'h08, 5'h08, 5'h08};
      "i":     return {5'h04, 5'h00, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h0e};
      "l":     return {5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      "o":     return {5'h00, 5'h00, 5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e};
      "r":     return {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      "t":     return {5'h08, 5'h08, 5'h1c, 5'h08, 5'h08, 5'h09, 5'h06};
      "w":     return {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0a};
      // unknown characters draw a hollow box
      default: return {5'h1f, 5'h11, 5'h15, 5'h15, 5'h11, 5'h1f, 5'h00};
    endcase
  endfunction

  // Move the cursor for one character and queue the scanlines it draws
  task automatic render_char(input logic [7:0] code, input logic fst,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
    logic [GLYPH_ROWS*GLYPH_COLS-1:0] rows;
    logic [GLYPH_COLS-1:0]            mask;
    logic [COORD_W-1:0]               y;
    scanline_t                        scan;
    int                               s;
    int                               count;
    s     = (int'(scale_r) > SGTR_MAX_SCALE) ? SGTR_MAX_SCALE : int'(scale_r);
    count = 0;
    if (fst) begin
      pen_x  = ox;
      home_x = ox;
      pen_y  = oy;
    end
    if (code == CHAR_NEWLINE) begin
      pen_x = home_x;
      pen_y = pen_y + COORD_W'((GLYPH_ROWS + 2) * s);
    end else if (code != CHAR_NUL) begin
      rows = font_rows(code);
      if (s != 0 && (bpp_r == BPP_3 || bpp_r == BPP_4)) begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          mask = rows[(GLYPH_ROWS - 1 - r) * GLYPH_COLS +: GLYPH_COLS];
          if (mask != '0) begin
            for (int dy = 0; dy < s; dy++) begin
              // wrap first, then clip against the frame height
              y = COORD_W'(int'(pen_y) + r * s + dy);
              if (y < fb_height_r) begin
                scan.x      = pen_x;
                scan.y      = y;
                scan.mask   = mask;
                scan.offset = OFFSET_W'(y) * OFFSET_W'(pitch_r)
                              + OFFSET_W'(pen_x) * OFFSET_W'(bpp_r);
                scan.last   = 1'b0;
                scanline_q.push_back(scan);
                count++;
              end
            end
          end
        end
        if (count > 0) begin
          scanline_q[scanline_q.size() - 1].last = 1'b1;
        end
      end
      pen_x = pen_x + COORD_W'((GLYPH_COLS + 1) * s);
    end
  endtask

  task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                             input logic [OFFSET_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare output first, then take register writes and accepted items
  always @(posedge clk) begin
    scanline_t want;
    if (rst) begin
      scale_r     = SCALE_RESET;
      fb_height_r = FB_HEIGHT_RESET;
      pitch_r     = PITCH_RESET;
      bpp_r       = BPP_RESET;
      pen_x       = '0;
      pen_y       = '0;
      home_x      = '0;
      scanline_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (scanline_q.size() == 0) begin
          $error("unexpected scanline item: line_x %0d line_y %0d", line_x, line_y);
          errors++;
        end else begin
          want = scanline_q.pop_front();
          check_field("line_x", OFFSET_W'(want.x), OFFSET_W'(line_x));
          check_field("line_y", OFFSET_W'(want.y), OFFSET_W'(line_y));
          check_field("column_mask", OFFSET_W'(want.mask), OFFSET_W'(column_mask));
          check_field("line_offset", want.offset, line_offset);
          check_field("last", OFFSET_W'(want.last), OFFSET_W'(last));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_SCALE:     scale_r     = cfg_data[SCALE_W-1:0];
          REG_FB_HEIGHT: fb_height_r = cfg_data[COORD_W-1:0];
          REG_PITCH:     pitch_r     = cfg_data[COORD_W-1:0];
          REG_BPP:       bpp_r       = cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        render_char(char_code, first, origin_x, origin_y);
      end
    end
    pending_cnt <= scanline_q.size();
  end

endmodule

`default_nettype wire

>>> tb/scaled_glyph_text_renderer_tb.sv
// Top of the scaled glyph text renderer testbench: clock, reset, register phases,
// character strings with random gaps and output stalls, and the final verdict.
// Depends on sgtr_pkg, the renderer and sgtr_scanline_checker.
`default_nettype none

module scaled_glyph_text_renderer_tb
  import sgtr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Walker drains at most a queue of full-size characters, plus margin
  localparam int SETTLE_CYCLES = 300;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [7:0]            char_code   = CHAR_NUL;
  logic                  first       = 1'b0;
  logic [COORD_W-1:0]    origin_x    = '0;
  logic [COORD_W-1:0]    origin_y    = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [COORD_W-1:0]    line_x;
  logic [COORD_W-1:0]    line_y;
  logic [GLYPH_COLS-1:0] column_mask;
  logic [OFFSET_W-1:0]   line_offset;
  logic                  last;
  int                    fail_count;
  int                    outstanding;

  logic                  quiet       = 1'b0;
  int                    stall_left  = 0;

  logic [7:0] font_chars [16] = '{" ", ",", ".", "H", "O", "R", "S", "d",
                                  "e", "f", "i", "l", "o", "r", "t", "w"};

  scaled_glyph_text_renderer dut (.*);

  sgtr_scanline_checker checker_i (.*);

  always #5 clk = ~clk;

  // Alternate stretches with and without idling
  always begin
    repeat ($urandom_range(200, 900)) @(posedge clk);
    quiet <= ~quiet;
  end

  // Stall the output: mostly short bursts, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19)) inside
        [0:11]:  begin out_stall <= 1'b0; stall_left = $urandom_range(0, 4); end
        [12:18]: begin out_stall <= 1'b1; stall_left = $urandom_range(0, 3); end
        default: begin out_stall <= 1'b1; stall_left = $urandom_range(8, 40); end
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Wait for every expected item, then let the walker finish undrawn jobs
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int scale, input int fbh, input int pitch, input int bpp);
    settle();
    write_reg(REG_SCALE, scale);
    write_reg(REG_FB_HEIGHT, fbh);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_BPP, bpp);
    cfg_write <= 1'b0;
  endtask

  // Offer one character, after a random gap, and hold it until taken
  task automatic send(input logic [7:0] code, input logic fst,
                      input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
    int gap;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 24)) inside
        [0:14]:  gap = 0;
        [15:22]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(8, 40);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    first     <= fst;
    origin_x  <= ox;
    origin_y  <= oy;
    do @(posedge clk); while (in_stall);
  endtask

  // Random text: mostly strings of known glyphs, with newlines, stray bytes and
  // strings restarted in the middle
  task automatic run_text(input int n, input int fbh);
    logic [7:0]         code;
    logic               fst;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic               fresh;
    fresh = 1'b1;
    for (int i = 0; i < n; i++) begin
      fst = fresh;
      ox  = COORD_W'($urandom);
      oy  = COORD_W'($urandom);
      if (fresh) begin
        if ($urandom_range(0, 9) != 0) ox = COORD_W'($urandom_range(0, 800));
        if ($urandom_range(0, 9) != 0) oy = COORD_W'($urandom_range(0, fbh));
      end
      case ($urandom_range(0, 99)) inside
        [0:69]:  code = font_chars[$urandom_range(0, 15)];
        [70:79]: code = CHAR_NEWLINE;
        [80:91]: code = 8'($urandom_range(0, 255));
        default: code = CHAR_NUL;
      endcase
      send(code, fst, ox, oy);
      fresh = (code == CHAR_NUL) || ($urandom_range(0, 19) == 0);
    end
  endtask

  task automatic random_phase(input int n);
    int scale;
    int fbh;
    int bpp;
    case ($urandom_range(0, 19)) inside
      [0:11]:  scale = $urandom_range(1, 2);
      [12:16]: scale = $urandom_range(3, 5);
      [17:18]: scale = $urandom_range(6, 8);
      default: scale = $urandom_range(9, 15);
    endcase
    fbh = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(100, 1200);
    bpp = ($urandom_range(0, 9) != 0) ? $urandom_range(3, 4) : $urandom_range(0, 7);
    set_config(scale, fbh, $urandom_range(1, 65535), bpp);
    run_text(n, fbh);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: every glyph, newline, unknown byte, wrap and clipping
    send("H", 1'b1, 16'd0, 16'd0);
    send("e", 1'b0, 16'd0, 16'd0);
    send("l", 1'b0, 16'd0, 16'd0);
    send("l", 1'b0, 16'd0, 16'd0);
    send("o", 1'b0, 16'd0, 16'd0);
    send(",", 1'b0, 16'd0, 16'd0);
    send(" ", 1'b0, 16'd0, 16'd0);
    send("w", 1'b0, 16'd0, 16'd0);
    send("o", 1'b0, 16'd0, 16'd0);
    send("r", 1'b0, 16'd0, 16'd0);
    send("l", 1'b0, 16'd0, 16'd0);
    send("d", 1'b0, 16'd0, 16'd0);
    send(".", 1'b0, 16'd0, 16'd0);
    send(CHAR_NEWLINE, 1'b0, 16'd0, 16'd0);
    send("R", 1'b0, 16'd0, 16'd0);
    send("O", 1'b0, 16'd0, 16'd0);
    send("S", 1'b0, 16'd0, 16'd0);
    send("f", 1'b0, 16'd0, 16'd0);
    send("i", 1'b0, 16'd0, 16'd0);
    send("t", 1'b0, 16'd0, 16'd0);
    send(8'hff, 1'b0, 16'd0, 16'd0);
    // terminator still loads the origin; the next glyph wraps in x and y
    send(CHAR_NUL, 1'b1, 16'hffff, 16'hffff);
    send("H", 1'b0, 16'd0, 16'd0);
    // fully clipped, then clipped after the top row
    send("O", 1'b1, 16'd10, 16'd1000);
    send("l", 1'b1, 16'd3, 16'd479);

    // Largest scale, height, pitch; three-byte pixels and y wrap
    set_config(SGTR_MAX_SCALE, 65535, 65535, BPP_3);
    send("w", 1'b1, 16'hffff, 16'hfffa);
    send(CHAR_NEWLINE, 1'b0, 16'd0, 16'd0);
    send("H", 1'b0, 16'd0, 16'd0);
    run_text(40, 65535);

    // Zero scale draws nothing and holds the cursor
    set_config(0, 480, 2560, BPP_4);
    run_text(20, 480);

    // Scale beyond the maximum saturates
    set_config(15, 200, 1, BPP_4);
    run_text(20, 200);

    // Pixel sizes with no output
    set_config(2, 480, 2560, 0);
    run_text(10, 480);
    set_config(2, 480, 2560, 7);
    run_text(10, 480);

    // Zero height and the smallest height and pitch
    set_config(3, 0, 640, BPP_4);
    run_text(10, 0);
    set_config(2, 1, 1, BPP_3);
    run_text(10, 1);

    for (int p = 0; p < 6; p++) begin
      random_phase(40);
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(40_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
